// ----- rtl/swdm_pkg.sv -----
// Shared types and constants of the serial-wire-debug host transfer engine.
package swdm_pkg;

   // Action codes of an input item.
   localparam logic [1:0] ACT_XFER   = 2'd0;
   localparam logic [1:0] ACT_SWITCH = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // Acknowledge codes as received, LSB first.
   localparam logic [2:0] ACK_OK    = 3'd1;
   localparam logic [2:0] ACK_WAIT  = 3'd2;
   localparam logic [2:0] ACK_FAULT = 3'd4;

   // Completion status codes.
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_WAIT     = 3'd1;
   localparam logic [2:0] STAT_FAULT    = 3'd2;
   localparam logic [2:0] STAT_PARITY   = 3'd3;
   localparam logic [2:0] STAT_PROTOCOL = 3'd4;

   // Fixed protocol lengths and patterns.
   localparam int REQUEST_BITS   = 8;
   localparam int ACK_BITS       = 3;
   localparam int DATA_BITS      = 32;
   localparam int BACKOFF_CYCLES = 34;
   localparam int SW_ZERO_CYCLES = 16;
   localparam int SW_PAT_BITS    = 16;
   localparam logic [15:0] SW_PATTERN_1 = 16'hE79E;
   localparam logic [15:0] SW_PATTERN_2 = 16'h6DB7;

   // Stream payload widths; the data widths are padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 56;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  request_header;
      logic [31:0] write_data;
      logic        swdio_in;
   } req_item_type;

   typedef struct packed {
      logic        swdio_out;
      logic        swdio_drive;
      logic        clock_pulse;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  status;
      logic [2:0]  ack_bits;
      logic [31:0] read_data;
      logic [7:0]  attempts_used;
   } rsp_item_type;

endpackage

// ----- rtl/swdm_core.sv -----
// Protocol sequencer: holds the link state and works out one SWCLK cycle per tick step.
module swdm_core #(
   parameter int IDLE_CYCLES       = 8,
   parameter int LINE_RESET_CYCLES = 51
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  swdm_pkg::req_item_type item,
   input  logic [7:0]            retry_limit,
   output swdm_pkg::rsp_item_type result
);
   import swdm_pkg::*;

   localparam int CNT_MAX_A = (LINE_RESET_CYCLES > BACKOFF_CYCLES) ?
                              LINE_RESET_CYCLES : BACKOFF_CYCLES;
   localparam int CNT_MAX   = (IDLE_CYCLES > CNT_MAX_A) ? IDLE_CYCLES : CNT_MAX_A;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_REQ, PH_TRN, PH_ACK, PH_RDATA, PH_TURN, PH_WDATA, PH_BACKOFF,
      PH_IDLEZ, PH_SWL1, PH_SWS1, PH_SWL2, PH_SWS2, PH_SWL3, PH_SWZ
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       header_ff, header_in;
   logic [31:0]      shift_ff, shift_in;
   logic [31:0]      hold_ff, hold_in;
   logic             parity_ff, parity_in;
   logic [2:0]       ack_ff, ack_in;
   logic [7:0]       retry_ff, retry_in;

   logic [CNT_W-1:0] cnt_inc;
   logic [2:0]       ack_new;
   logic [7:0]       limit;
   logic             is_read;
   logic [15:0]      pattern;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      header_in = header_ff;
      shift_in  = shift_ff;
      hold_in   = hold_ff;
      parity_in = parity_ff;
      ack_in    = ack_ff;
      retry_in  = retry_ff;

      cnt_inc = cnt_ff + 1'b1;
      ack_new = ack_ff | (3'(item.swdio_in) << cnt_ff[1:0]);
      limit   = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
      is_read = header_ff[1];
      pattern = (phase_ff == PH_SWS1) ? SW_PATTERN_1 : SW_PATTERN_2;

      result             = '0;
      result.swdio_out   = 1'b1;
      result.swdio_drive = 1'b1;
      result.busy_res    = (phase_ff != PH_IDLE);

      if (item.action == ACT_XFER || item.action == ACT_SWITCH) begin
         if (phase_ff == PH_IDLE) begin
            result.busy_res = 1'b1;
            cnt_in = '0;
            ack_in = '0;
            if (item.action == ACT_XFER) begin
               header_in = item.request_header;
               hold_in   = item.write_data;
               retry_in  = 8'd1;
               phase_in  = PH_REQ;
               parity_in = 1'b0;
               shift_in  = '0;
            end else begin
               phase_in = PH_SWL1;
               retry_in = 8'd0;
            end
         end
      end else if (item.action == ACT_TICK && phase_ff != PH_IDLE) begin
         result.clock_pulse = 1'b1;
         unique case (phase_ff)
            PH_REQ: begin
               // Start, APnDP, RnW, A2, A3, parity, stop, park.
               case (cnt_ff[2:0])
                  3'd0:    result.swdio_out = 1'b1;
                  3'd5:    result.swdio_out = ^header_ff;
                  3'd6:    result.swdio_out = 1'b0;
                  3'd7:    result.swdio_out = 1'b1;
                  default: result.swdio_out = header_ff[cnt_ff[1:0] - 2'd1];
               endcase
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(REQUEST_BITS - 1)) begin
                  phase_in = PH_TRN;
                  cnt_in   = '0;
               end
            end
            PH_TRN: begin
               result.swdio_out   = 1'b0;
               result.swdio_drive = 1'b0;
               phase_in = PH_ACK;
               cnt_in   = '0;
            end
            PH_ACK: begin
               result.swdio_out   = 1'b0;
               result.swdio_drive = 1'b0;
               ack_in = ack_new;
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(ACK_BITS - 1)) begin
                  cnt_in = '0;
                  if (ack_new == ACK_OK) begin
                     phase_in = is_read ? PH_RDATA : PH_TURN;
                  end else if (ack_new == ACK_WAIT || ack_new == ACK_FAULT) begin
                     phase_in = PH_TURN;
                  end else begin
                     phase_in = PH_BACKOFF;
                  end
               end
            end
            PH_RDATA: begin
               result.swdio_out   = 1'b0;
               result.swdio_drive = 1'b0;
               if (cnt_ff < CNT_W'(DATA_BITS)) begin
                  shift_in = {item.swdio_in, shift_ff[31:1]};
               end
               parity_in = parity_ff ^ item.swdio_in;
               cnt_in    = cnt_inc;
               if (cnt_ff == CNT_W'(DATA_BITS)) begin
                  phase_in = PH_TURN;
                  cnt_in   = '0;
               end
            end
            PH_TURN: begin
               result.swdio_out   = 1'b0;
               result.swdio_drive = 1'b0;
               phase_in = (ack_ff == ACK_OK && !is_read) ? PH_WDATA : PH_IDLEZ;
               cnt_in   = '0;
            end
            PH_WDATA: begin
               result.swdio_out = (cnt_ff < CNT_W'(DATA_BITS)) ? hold_ff[cnt_ff[4:0]] :
                                  ^hold_ff;
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(DATA_BITS)) begin
                  phase_in = PH_IDLEZ;
                  cnt_in   = '0;
               end
            end
            PH_BACKOFF: begin
               result.swdio_out   = 1'b0;
               result.swdio_drive = 1'b0;
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(BACKOFF_CYCLES - 1)) begin
                  phase_in = PH_IDLEZ;
                  cnt_in   = '0;
               end
            end
            PH_IDLEZ: begin
               result.swdio_out = 1'b0;
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(IDLE_CYCLES - 1)) begin
                  cnt_in = '0;
                  if (ack_ff == ACK_WAIT && retry_ff < limit) begin
                     // Another attempt after a WAIT answer.
                     retry_in  = retry_ff + 8'd1;
                     phase_in  = PH_REQ;
                     ack_in    = '0;
                     parity_in = 1'b0;
                     shift_in  = '0;
                  end else begin
                     result.done_res      = 1'b1;
                     result.ack_bits      = ack_ff;
                     result.attempts_used = retry_ff;
                     if (ack_ff == ACK_OK) begin
                        result.status = (is_read && parity_ff) ? STAT_PARITY : STAT_OK;
                        if (is_read) begin
                           result.read_data = shift_ff;
                        end
                     end else if (ack_ff == ACK_WAIT) begin
                        result.status = STAT_WAIT;
                     end else if (ack_ff == ACK_FAULT) begin
                        result.status = STAT_FAULT;
                     end else begin
                        result.status = STAT_PROTOCOL;
                     end
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_SWL1, PH_SWL2, PH_SWL3: begin
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(LINE_RESET_CYCLES - 1)) begin
                  cnt_in = '0;
                  case (phase_ff)
                     PH_SWL1: phase_in = PH_SWS1;
                     PH_SWL2: phase_in = PH_SWS2;
                     default: phase_in = PH_SWZ;
                  endcase
               end
            end
            PH_SWS1, PH_SWS2: begin
               result.swdio_out = pattern[cnt_ff[3:0]];
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(SW_PAT_BITS - 1)) begin
                  cnt_in   = '0;
                  phase_in = (phase_ff == PH_SWS1) ? PH_SWL2 : PH_SWL3;
               end
            end
            PH_SWZ: begin
               result.swdio_out = 1'b0;
               cnt_in = cnt_inc;
               if (cnt_ff == CNT_W'(SW_ZERO_CYCLES - 1)) begin
                  result.done_res = 1'b1;
                  phase_in = PH_IDLE;
                  cnt_in   = '0;
               end
            end
            default: begin
               result.clock_pulse = 1'b0;
               phase_in = PH_IDLE;
               cnt_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         header_ff <= '0;
         shift_ff  <= '0;
         hold_ff   <= '0;
         parity_ff <= 1'b0;
         ack_ff    <= '0;
         retry_ff  <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         header_ff <= header_in;
         shift_ff  <= shift_in;
         hold_ff   <= hold_in;
         parity_ff <= parity_in;
         ack_ff    <= ack_in;
         retry_ff  <= retry_in;
      end
   end

endmodule

// ----- rtl/swd_master_transfer_engine_top.sv -----
// Top level of the serial-wire-debug host transfer engine: stream ports and staging.
//
// Each request transfer is one action: start a transfer, start the JTAG-to-SWD switch
// sequence, or one SWCLK tick; every request yields exactly one response. The engine
// takes one request per clock while the response side is not stalled. A request waits
// in the input register, then the sequencer state update and the response register are
// written in the same edge, so the rate is set by that single update path.
// A waiting response does not block the input: the input register holds one more
// request. The retry limit resets to 10; the user must write it only while no operation
// runs, and the block itself does not enforce this. There is no clearing pass after reset.
module swd_master_transfer_engine_top #(
   parameter int IDLE_CYCLES       = 8,
   parameter int LINE_RESET_CYCLES = 51
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // request_header[3:0], write_data[35:4], swdio_in[36], zero fill above
   input  logic [swdm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [swdm_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // swdio_out[0], swdio_drive[1], clock_pulse[2], busy_res[3], done_res[4],
   // status[7:5], ack_bits[10:8], read_data[42:11], attempts_used[50:43], zero fill above
   output logic [swdm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [7:0]                        csr_wdata
);
   import swdm_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic [7:0]   retry_limit_ff;
   logic         out_free;
   logic         advance;
   rsp_item_type step_result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;

   assign rsp_tdata = {{(RSP_TDATA_W - 51){1'b0}},
                       rsp_item_ff.attempts_used, rsp_item_ff.read_data,
                       rsp_item_ff.ack_bits, rsp_item_ff.status,
                       rsp_item_ff.done_res, rsp_item_ff.busy_res,
                       rsp_item_ff.clock_pulse, rsp_item_ff.swdio_drive,
                       rsp_item_ff.swdio_out};

   swdm_core #(
      .IDLE_CYCLES       (IDLE_CYCLES),
      .LINE_RESET_CYCLES (LINE_RESET_CYCLES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (in_item_ff),
      .retry_limit (retry_limit_ff),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         retry_limit_ff <= 8'd10;
      end else begin
         if (csr_we) begin
            retry_limit_ff <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         in_item_ff.action         <= req_tuser[1:0];
         in_item_ff.request_header <= req_tdata[3:0];
         in_item_ff.write_data     <= req_tdata[35:4];
         in_item_ff.swdio_in       <= req_tdata[36];
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   // A finished operation always comes with a clock pulse and a busy flag.
   a_done_is_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.done_res) |->
         (rsp_item_ff.clock_pulse && rsp_item_ff.busy_res))
      else $error("done response without clock pulse or busy");

   // The host never shows a high level on a line it has released, and releases it only on a tick.
   a_released_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.swdio_drive) |->
         (!rsp_item_ff.swdio_out && rsp_item_ff.clock_pulse))
      else $error("released line reported high or outside a tick");

   // Completion fields stay zero except on the finishing tick.
   a_result_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.done_res) |->
         (rsp_item_ff.status == STAT_OK && rsp_item_ff.read_data == 32'd0 &&
          rsp_item_ff.attempts_used == 8'd0 && rsp_item_ff.ack_bits == 3'd0))
      else $error("completion fields set off the done tick");

   // A new response is loaded only when the previous one has gone or is taken now.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && !$past(advance)))
      else $error("pending response overwritten");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the serial-wire-debug host transfer engine, with a target model.
`timescale 1ns / 100ps

module tb_top;
   import swdm_pkg::*;

   localparam int IDLE_CYCLES       = 8;
   localparam int LINE_RESET_CYCLES = 51;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE, PH_REQ, PH_TRN, PH_ACK, PH_RDATA, PH_TURN, PH_WDATA, PH_BACKOFF, PH_IDLEZ,
      PH_SWL1, PH_SWS1, PH_SWL2, PH_SWS2, PH_SWL3, PH_SWZ
   } seq_phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [7:0]             csr_wdata;

   // Our own copy of the sequencer state, advanced once per accepted request.
   seq_phase_type seq_phase   = PH_IDLE;
   int unsigned bit_cnt       = 0;
   logic [3:0]  hdr_q         = '0;
   logic [31:0] wdata_q       = '0;
   logic [31:0] rdata_shift   = '0;
   logic        par_acc       = 1'b0;
   logic [2:0]  ack_q         = '0;
   logic [7:0]  attempt_cnt   = '0;
   logic [7:0]  retry_limit_q = 8'd10;

   rsp_item_type swd_out_q[$];
   int fail_count    = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;

   swd_master_transfer_engine_top #(
      .IDLE_CYCLES      (IDLE_CYCLES),
      .LINE_RESET_CYCLES(LINE_RESET_CYCLES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void start_attempt();
      seq_phase   = PH_REQ;
      bit_cnt     = 0;
      ack_q       = '0;
      par_acc     = 1'b0;
      rdata_shift = '0;
   endfunction

   function automatic rsp_item_type swd_engine_step(input req_item_type it);
      rsp_item_type r;
      logic         rd_op;
      logic [7:0]   lim;
      logic [15:0]  pat;
      r             = '0;
      r.swdio_out   = 1'b1;
      r.swdio_drive = 1'b1;
      r.busy_res    = (seq_phase != PH_IDLE);
      rd_op         = hdr_q[1];
      if (it.action == ACT_XFER || it.action == ACT_SWITCH) begin
         // A start while an operation runs is dropped without a clock pulse.
         if (seq_phase == PH_IDLE) begin
            r.busy_res = 1'b1;
            if (it.action == ACT_XFER) begin
               hdr_q       = it.request_header;
               wdata_q     = it.write_data;
               attempt_cnt = 8'd1;
               start_attempt();
            end else begin
               seq_phase   = PH_SWL1;
               bit_cnt     = 0;
               attempt_cnt = '0;
               ack_q       = '0;
            end
         end
      end else if (it.action == ACT_TICK && seq_phase != PH_IDLE) begin
         r.clock_pulse = 1'b1;
         case (seq_phase)
            PH_REQ: begin
               case (bit_cnt)
                  0:          r.swdio_out = 1'b1;
                  1, 2, 3, 4: r.swdio_out = hdr_q[bit_cnt - 1];
                  5:          r.swdio_out = ^hdr_q;
                  6:          r.swdio_out = 1'b0;
                  default:    r.swdio_out = 1'b1;
               endcase
               bit_cnt++;
               if (bit_cnt >= REQUEST_BITS) begin
                  seq_phase = PH_TRN;
                  bit_cnt   = 0;
               end
            end
            PH_TRN: begin
               r.swdio_out   = 1'b0;
               r.swdio_drive = 1'b0;
               seq_phase     = PH_ACK;
               bit_cnt       = 0;
            end
            PH_ACK: begin
               r.swdio_out    = 1'b0;
               r.swdio_drive  = 1'b0;
               ack_q[bit_cnt] = ack_q[bit_cnt] | it.swdio_in;
               bit_cnt++;
               if (bit_cnt >= ACK_BITS) begin
                  bit_cnt = 0;
                  if (ack_q == ACK_OK) seq_phase = rd_op ? PH_RDATA : PH_TURN;
                  else if (ack_q == ACK_WAIT || ack_q == ACK_FAULT) seq_phase = PH_TURN;
                  else seq_phase = PH_BACKOFF;
               end
            end
            PH_RDATA: begin
               r.swdio_out   = 1'b0;
               r.swdio_drive = 1'b0;
               if (bit_cnt < DATA_BITS) rdata_shift = {it.swdio_in, rdata_shift[31:1]};
               par_acc = par_acc ^ it.swdio_in;
               bit_cnt++;
               if (bit_cnt >= DATA_BITS + 1) begin
                  seq_phase = PH_TURN;
                  bit_cnt   = 0;
               end
            end
            PH_TURN: begin
               r.swdio_out   = 1'b0;
               r.swdio_drive = 1'b0;
               seq_phase     = (ack_q == ACK_OK && !rd_op) ? PH_WDATA : PH_IDLEZ;
               bit_cnt       = 0;
            end
            PH_WDATA: begin
               r.swdio_out = (bit_cnt < DATA_BITS) ? wdata_q[bit_cnt] : ^wdata_q;
               bit_cnt++;
               if (bit_cnt >= DATA_BITS + 1) begin
                  seq_phase = PH_IDLEZ;
                  bit_cnt   = 0;
               end
            end
            PH_BACKOFF: begin
               r.swdio_out   = 1'b0;
               r.swdio_drive = 1'b0;
               bit_cnt++;
               if (bit_cnt >= BACKOFF_CYCLES) begin
                  seq_phase = PH_IDLEZ;
                  bit_cnt   = 0;
               end
            end
            PH_IDLEZ: begin
               // A limit of zero still allows the first attempt.
               lim         = (retry_limit_q == 0) ? 8'd1 : retry_limit_q;
               r.swdio_out = 1'b0;
               bit_cnt++;
               if (bit_cnt >= IDLE_CYCLES) begin
                  bit_cnt = 0;
                  if (ack_q == ACK_WAIT && attempt_cnt < lim) begin
                     attempt_cnt++;
                     start_attempt();
                  end else begin
                     r.done_res      = 1'b1;
                     r.ack_bits      = ack_q;
                     r.attempts_used = attempt_cnt;
                     if (ack_q == ACK_OK) begin
                        r.status = (rd_op && par_acc) ? STAT_PARITY : STAT_OK;
                        if (rd_op) r.read_data = rdata_shift;
                     end else if (ack_q == ACK_WAIT) begin
                        r.status = STAT_WAIT;
                     end else if (ack_q == ACK_FAULT) begin
                        r.status = STAT_FAULT;
                     end else begin
                        r.status = STAT_PROTOCOL;
                     end
                     seq_phase = PH_IDLE;
                  end
               end
            end
            PH_SWL1, PH_SWL2, PH_SWL3: begin
               bit_cnt++;
               if (bit_cnt >= LINE_RESET_CYCLES) begin
                  seq_phase = seq_phase_type'(seq_phase + 1);
                  bit_cnt   = 0;
               end
            end
            PH_SWS1, PH_SWS2: begin
               pat         = (seq_phase == PH_SWS1) ? SW_PATTERN_1 : SW_PATTERN_2;
               r.swdio_out = pat[bit_cnt % SW_PAT_BITS];
               bit_cnt++;
               if (bit_cnt >= SW_PAT_BITS) begin
                  seq_phase = seq_phase_type'(seq_phase + 1);
                  bit_cnt   = 0;
               end
            end
            PH_SWZ: begin
               r.swdio_out = 1'b0;
               bit_cnt++;
               if (bit_cnt >= SW_ZERO_CYCLES) begin
                  r.done_res = 1'b1;
                  seq_phase  = PH_IDLE;
                  bit_cnt    = 0;
               end
            end
            default: begin
               r.clock_pulse = 1'b0;
               seq_phase     = PH_IDLE;
               bit_cnt       = 0;
            end
         endcase
      end
      return r;
   endfunction

   function automatic req_item_type make_item(input logic [1:0] act, input logic [3:0] hdr,
                                              input logic [31:0] wd, input logic sin);
      req_item_type it;
      it.action         = act;
      it.request_header = hdr;
      it.write_data     = wd;
      it.swdio_in       = sin;
      return it;
   endfunction

   // Offers one request; valid stays high afterwards until the next call or a drain.
   task automatic send_item(input req_item_type it, input bit counted);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= REQ_TDATA_W'({it.swdio_in, it.write_data, it.request_header});
      do @(posedge clock); while (!req_tready);
      swd_out_q.push_back(swd_engine_step(it));
      if (counted) items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (swd_out_q.size() != 0);
   endtask

   task automatic write_retry_limit(input logic [7:0] value);
      drain();
      // Responses trail acceptance through the input and response registers; let the sequencer settle first.
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we        <= 1'b0;
      retry_limit_q = value;
   endtask

   // Starts that arrive while busy and unused action codes; only sent mid-operation.
   task automatic send_noise();
      logic [1:0] act;
      case ($urandom_range(0, 2))
         0:       act = ACT_XFER;
         1:       act = ACT_SWITCH;
         default: act = ACT_UNUSED;
      endcase
      send_item(make_item(act, 4'($urandom), $urandom, 1'($urandom)), 1'b0);
   endtask

   // Ticks the running operation to its end while playing the target side of the wire.
   task automatic finish_operation(input int n_wait, input logic [2:0] final_ack,
                                   input logic [31:0] word, input logic flip,
                                   input int noise_pct);
      logic [2:0] ack;
      logic       sin;
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_noise();
         end else begin
            ack = (attempt_cnt <= n_wait) ? ACK_WAIT : final_ack;
            if (seq_phase == PH_ACK) sin = ack[bit_cnt];
            else if (seq_phase == PH_RDATA)
               sin = (bit_cnt < DATA_BITS) ? word[bit_cnt] : (^word ^ flip);
            else sin = 1'($urandom);
            send_item(make_item(ACT_TICK, 4'($urandom), $urandom, sin), 1'b1);
         end
      end
   endtask

   task automatic run_transfer(input logic [3:0] hdr, input logic [31:0] wd, input int n_wait,
                               input logic [2:0] final_ack, input logic [31:0] word,
                               input logic flip, input int noise_pct);
      send_item(make_item(ACT_XFER, hdr, wd, 1'($urandom)), 1'b1);
      finish_operation(n_wait, final_ack, word, flip, noise_pct);
   endtask

   task automatic run_switch(input int noise_pct);
      send_item(make_item(ACT_SWITCH, 4'($urandom), $urandom, 1'($urandom)), 1'b1);
      finish_operation(0, ACK_OK, '0, 1'b0, noise_pct);
   endtask

   task automatic random_transfer();
      int          r;
      int          n_wait;
      int          lim;
      logic [2:0]  fin;
      logic [31:0] word;
      lim = (retry_limit_q == 0) ? 1 : retry_limit_q;
      r   = $urandom_range(0, 99);
      if (r < 70) n_wait = 0;
      else if (r < 90) n_wait = $urandom_range(1, 3);
      else n_wait = (lim <= 12) ? $urandom_range(0, lim + 1) : 5;
      r = $urandom_range(0, 99);
      if (r < 55) fin = ACK_OK;
      else if (r < 68) fin = ACK_FAULT;
      else if (r < 78) fin = ACK_WAIT;
      else fin = 3'($urandom);
      // Running out of retries at a high limit would take too long.
      if (fin == ACK_WAIT && lim > 12) fin = ACK_FAULT;
      case ($urandom_range(0, 7))
         0:       word = '0;
         1:       word = '1;
         default: word = $urandom;
      endcase
      run_transfer(4'($urandom), $urandom, n_wait, fin, word, ($urandom_range(0, 4) == 0), 5);
   endtask

   task automatic test_idle_edges_and_fault();
      send_item(make_item(ACT_TICK, 4'h0, 32'h0000_0000, 1'b1), 1'b1);
      send_item(make_item(ACT_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b0), 1'b1);
      send_item(make_item(ACT_XFER, 4'hF, 32'hFFFF_FFFF, 1'b1), 1'b1);
      send_item(make_item(ACT_XFER, 4'h0, 32'h0000_0000, 1'b0), 1'b0);
      send_item(make_item(ACT_SWITCH, 4'h0, 32'h0000_0000, 1'b0), 1'b0);
      finish_operation(0, ACK_FAULT, '0, 1'b0, 0);
   endtask

   task automatic test_switch_sequence();
      run_switch(10);
   endtask

   task automatic test_retry_limit_extremes();
      write_retry_limit(8'd0);
      run_transfer(4'h2, $urandom, 1, ACK_OK, $urandom, 1'b0, 0);
      write_retry_limit(8'd255);
      run_transfer(4'hA, $urandom, 3, ACK_OK, $urandom, 1'b0, 0);
      write_retry_limit(8'd2);
      run_transfer(4'h5, $urandom, 5, ACK_OK, $urandom, 1'b0, 0);
      write_retry_limit(8'd1);
      run_transfer(4'h0, 32'hA5A5_5A5A, 0, ACK_OK, '0, 1'b0, 0);
      run_transfer(4'hE, $urandom, 0, 3'd7, '0, 1'b0, 0);
      run_transfer(4'h6, $urandom, 0, ACK_OK, $urandom, 1'b1, 0);
   endtask

   task automatic test_random_traffic(input int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 3) run_switch(3);
         else random_transfer();
      end
   endtask

   // The receiver stalls long enough for the engine to fill and stall its input.
   task automatic test_backpressure();
      hold_left = 300;
      random_transfer();
      random_transfer();
      drain();
      random_transfer();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 74;
      test_idle_edges_and_fault();
      test_switch_sequence();
      test_retry_limit_extremes();
      write_retry_limit(8'd3);
      test_random_traffic(150);
      test_backpressure();
      send_idle_pct = 74;
      recv_idle_pct = 8;
      write_retry_limit(8'($urandom_range(4, 12)));
      test_random_traffic(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_retry_limit(8'd255);
      test_random_traffic(150);
      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   initial begin
      rsp_item_type got;
      rsp_item_type want;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.swdio_out     = rsp_tdata[0];
            got.swdio_drive   = rsp_tdata[1];
            got.clock_pulse   = rsp_tdata[2];
            got.busy_res      = rsp_tdata[3];
            got.done_res      = rsp_tdata[4];
            got.status        = rsp_tdata[7:5];
            got.ack_bits      = rsp_tdata[10:8];
            got.read_data     = rsp_tdata[42:11];
            got.attempts_used = rsp_tdata[50:43];
            if (swd_out_q.size() == 0) begin
               $error("response transfer arrived with nothing predicted");
               fail_count++;
            end else begin
               want = swd_out_q.pop_front();
               check_field("swdio_out", 32'(want.swdio_out), 32'(got.swdio_out));
               check_field("swdio_drive", 32'(want.swdio_drive), 32'(got.swdio_drive));
               check_field("clock_pulse", 32'(want.clock_pulse), 32'(got.clock_pulse));
               check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
               check_field("done_res", 32'(want.done_res), 32'(got.done_res));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("ack_bits", 32'(want.ack_bits), 32'(got.ack_bits));
               check_field("read_data", want.read_data, got.read_data);
               check_field("attempts_used", 32'(want.attempts_used),
                           32'(got.attempts_used));
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
